// ----- sv/cis_pkg.sv -----
`default_nettype none
package cis_pkg;
    localparam int DEPTH = 1024;
    localparam int AW = 10;
    localparam int KW = 64;
    localparam int MW = 10;          // multiplier width for hi-lo
    localparam logic [4:0] PROBE_MAX = 5'd31;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_LO,
        ST_WT_LO,
        ST_RD_HI,
        ST_CHECK,
        ST_DIV,
        ST_RD_P,
        ST_WT_P,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic         start;
        logic [KW-1:0] num;
        logic [KW-1:0] den;
        logic [MW-1:0] mul;
    } div_req_t;
endpackage
`default_nettype wire

// ----- sv/cis_div.sv -----
`default_nettype none
// floor(num*mul/den), num <= den, one multiplier bit per cycle
module cis_div (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cis_pkg::div_req_t     req,
    output logic                       done,
    output logic [cis_pkg::MW-1:0]     quot
);
    logic [cis_pkg::KW-1:0] num_reg, den_reg, r_reg, r_next;
    logic [cis_pkg::MW-1:0] m_reg, q_reg, q_next;
    logic [3:0] cnt_reg;
    logic       busy_reg;
    logic [cis_pkg::KW:0] t, s;
    logic [cis_pkg::KW-1:0] r1;
    logic [cis_pkg::MW-1:0] q1;

    always_comb
    begin
        t = {r_reg, 1'b0};
        s = '0;
        q1 = {q_reg[cis_pkg::MW-2:0], 1'b0};
        if (t >= {1'b0, den_reg})
        begin
            t = t - {1'b0, den_reg};
            q1 = q1 + cis_pkg::MW'(1);
        end
        r1 = t[cis_pkg::KW-1:0];
        q_next = q1;
        r_next = r1;
        if (m_reg[cis_pkg::MW-1])
        begin
            s = {1'b0, r1} + {1'b0, num_reg};
            if (s >= {1'b0, den_reg})
            begin
                s = s - {1'b0, den_reg};
                q_next = q1 + cis_pkg::MW'(1);
            end
            r_next = s[cis_pkg::KW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 4'(cis_pkg::MW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
                cnt_reg <= cnt_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            m_reg <= req.mul;
            r_reg <= '0;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            q_reg <= q_next;
            m_reg <= {m_reg[cis_pkg::MW-2:0], 1'b0};
        end
    end

    assign quot = q_reg;
endmodule
`default_nettype wire

// ----- sv/cis_ctrl.sv -----
`default_nettype none
module cis_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic                   mode,
    input  wire logic [63:0]            search_key,
    input  wire logic [9:0]             write_index,
    input  wire logic [9:0]             low_bound,
    input  wire logic signed [10:0]     high_bound,
    output logic                        busy,
    output logic                        strobe,
    output logic                        found,
    output logic [9:0]                  position,
    output logic [4:0]                  probe_count
);
    logic [cis_pkg::KW-1:0] mem [cis_pkg::DEPTH];
    logic [cis_pkg::KW-1:0] rdata;
    logic [cis_pkg::AW-1:0] raddr;

    cis_pkg::state_t state_reg, state_next;
    logic [cis_pkg::KW-1:0] v_reg, alo_reg, ahi_reg;
    logic [cis_pkg::AW-1:0] lo_reg, hi_reg, p_reg;
    logic [cis_pkg::AW-1:0] lo_next, hi_next, p_next;
    logic [4:0] probes_reg, probes_next, used_reg, used_next, cap_reg;
    logic alo_ld, ahi_ld;
    cis_pkg::div_req_t dreq;
    logic ddone;
    logic [cis_pkg::MW-1:0] quot;
    logic [cis_pkg::AW:0] span;
    logic [4:0] cap_calc;
    logic [cis_pkg::AW-1:0] qsat;
    logic [cis_pkg::KW-1:0] vord;
    logic [cis_pkg::AW-1:0] hsat;
    logic hempty;

    assign vord = search_key ^ {1'b1, {(cis_pkg::KW-1){1'b0}}};
    assign hempty = high_bound[10] || (high_bound[9:0] < low_bound);
    assign hsat = high_bound[9:0];
    assign span = {1'b0, hsat} - {1'b0, low_bound} + 11'd2;

    always_comb
    begin
        cap_calc = 5'd0;
        for (int k = 11; k >= 0; k--)
            if ((12'd1 << k) >= {1'b0, span}) cap_calc = 5'(k);
        cap_calc = cap_calc + 5'd1;
    end

    assign qsat = (quot > (hi_reg - lo_reg)) ? (hi_reg - lo_reg) : quot;

    always_ff @(posedge clk)
    begin
        if (start && !busy && !mode)
            mem[write_index] <= vord;
        rdata <= mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        p_next = p_reg;
        probes_next = probes_reg;
        used_next = used_reg;
        raddr = lo_reg;
        alo_ld = 1'b0;
        ahi_ld = 1'b0;
        dreq = '0;
        dreq.num = v_reg - alo_reg;
        dreq.den = ahi_reg - alo_reg;
        dreq.mul = hi_reg - lo_reg;
        unique case (state_reg)
            cis_pkg::ST_IDLE:
            begin
                if (start && mode)
                    state_next = hempty ? cis_pkg::ST_DONE : cis_pkg::ST_RD_LO;
            end
            cis_pkg::ST_RD_LO:
            begin
                raddr = lo_reg;
                state_next = cis_pkg::ST_WT_LO;
            end
            cis_pkg::ST_WT_LO:
            begin
                raddr = hi_reg;
                alo_ld = 1'b1;
                state_next = cis_pkg::ST_RD_HI;
            end
            cis_pkg::ST_RD_HI:
            begin
                ahi_ld = 1'b1;
                state_next = cis_pkg::ST_CHECK;
            end
            cis_pkg::ST_CHECK:
            begin
                if (alo_reg > v_reg || ahi_reg < v_reg)
                    state_next = cis_pkg::ST_DONE;
                else if (alo_reg == ahi_reg)
                begin
                    probes_next = probes_reg + 5'd1;
                    state_next = cis_pkg::ST_DONE;
                end
                else if (used_reg < cap_reg)
                begin
                    dreq.start = 1'b1;
                    used_next = used_reg + 5'd1;
                    state_next = cis_pkg::ST_DIV;
                end
                else
                begin
                    p_next = lo_reg + ((hi_reg - lo_reg) >> 1);
                    state_next = cis_pkg::ST_RD_P;
                end
            end
            cis_pkg::ST_DIV:
            begin
                if (ddone)
                begin
                    p_next = lo_reg + qsat;
                    state_next = cis_pkg::ST_RD_P;
                end
            end
            cis_pkg::ST_RD_P:
            begin
                raddr = p_reg;
                probes_next = probes_reg + 5'd1;
                state_next = cis_pkg::ST_WT_P;
            end
            cis_pkg::ST_WT_P:
            begin
                // keep the probed entry on rdata for the compare
                raddr = p_reg;
                state_next = cis_pkg::ST_CMP;
            end
            cis_pkg::ST_CMP:
            begin
                if (rdata == v_reg)
                    state_next = cis_pkg::ST_DONE;
                else if (rdata < v_reg)
                begin
                    if (p_reg == hi_reg)
                        state_next = cis_pkg::ST_DONE;
                    else
                    begin
                        lo_next = p_reg + cis_pkg::AW'(1);
                        state_next = cis_pkg::ST_RD_LO;
                    end
                end
                else
                begin
                    if (p_reg == lo_reg)
                        state_next = cis_pkg::ST_DONE;
                    else
                    begin
                        hi_next = p_reg - cis_pkg::AW'(1);
                        state_next = cis_pkg::ST_RD_LO;
                    end
                end
            end
            cis_pkg::ST_DONE:
            begin
                state_next = cis_pkg::ST_IDLE;
            end
            default: state_next = cis_pkg::ST_IDLE;
        endcase
    end

    cis_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .done  (ddone),
        .quot  (quot)
    );

    logic hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cis_pkg::ST_IDLE;
            strobe <= 1'b0;
            found <= 1'b0;
            position <= '0;
            probe_count <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            strobe <= (state_reg == cis_pkg::ST_DONE);
            if (state_reg == cis_pkg::ST_DONE)
            begin
                found <= hit_reg;
                position <= hit_reg ? p_reg : '0;
                probe_count <= probes_reg;
            end
            if (state_reg == cis_pkg::ST_IDLE)
                hit_reg <= 1'b0;
            else if (state_reg == cis_pkg::ST_CMP && rdata == v_reg)
                hit_reg <= 1'b1;
            else if (state_reg == cis_pkg::ST_CHECK && !(alo_reg > v_reg || ahi_reg < v_reg)
                     && alo_reg == ahi_reg && alo_reg == v_reg)
                hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == cis_pkg::ST_IDLE)
        begin
            v_reg <= vord;
            lo_reg <= low_bound;
            hi_reg <= hsat;
            cap_reg <= cap_calc;
            probes_reg <= '0;
            used_reg <= '0;
            p_reg <= '0;
        end
        else
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            probes_reg <= (probes_next > probes_reg) ? probes_next : probes_reg;
            used_reg <= used_next;
            // single-probe equal ends report lo
            if (state_reg == cis_pkg::ST_CHECK && alo_reg == ahi_reg)
                p_reg <= lo_reg;
            else
                p_reg <= p_next;
        end
        if (alo_ld) alo_reg <= rdata;
        if (ahi_ld) ahi_reg <= rdata;
    end

    assign busy = (state_reg != cis_pkg::ST_IDLE);
endmodule
`default_nettype wire

// ----- sv/capped_interpolation_search_unit.sv -----
`default_nettype none
// Sorted-key store with interpolation search and binary fallback.
// Command channel: a word is taken when start is high and busy is low.
// mode 0 writes search_key, sign bit flipped, into entry write_index (no result).
// mode 1 searches [low_bound, high_bound] for search_key; one result word
// follows, shown for one cycle with strobe high: found, position,
// probe_count. The receiver cannot stall; it must take the word.
// An empty bracket goes straight to the result. Each pass reads and checks
// both bracket ends (RD_LO, WT_LO, RD_HI, CHECK); a binary probe then reads
// and compares one entry (RD_P, WT_P, CMP), and an interpolation probe
// first waits in DIV for the bit-serial divider. The result word is then
// registered out of DONE.
// One search in flight at a time; busy drops as strobe rises, so the next
// word can be taken during the result cycle.
// Reset returns the controller to idle; the key memory is not cleared and
// entries read before being written give undefined results.
module capped_interpolation_search_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               mode,
    input  wire logic [63:0]        search_key,
    input  wire logic [9:0]         write_index,
    input  wire logic [9:0]         low_bound,
    input  wire logic signed [10:0] high_bound,
    output logic                    strobe,
    output logic                    found,
    output logic [9:0]              position,
    output logic [4:0]              probe_count
);
    cis_ctrl u_ctrl (
        .clk, .rst_n, .start, .mode, .search_key, .write_index,
        .low_bound, .high_bound, .busy, .strobe, .found, .position,
        .probe_count
    );
endmodule
`default_nettype wire

// ----- sv/cis_checker.sv -----
`default_nettype none
module cis_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       mode,
    input wire logic       strobe,
    input wire logic       found,
    input wire logic [9:0] position,
    input wire logic [4:0] probe_count
);
    a_nf_pos: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !found |-> position == 10'd0) else $error("position not zero");
    a_found_probe: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && found |-> probe_count != 5'd0) else $error("found without probe");
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !mode |=> !busy) else $error("write made busy");
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && mode |=> busy) else $error("search not started");
endmodule

bind capped_interpolation_search_unit cis_checker u_chk (.*);
`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none
module tb;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        bit       hit;
        bit [9:0] pos;
        bit [4:0] probes;
    } search_result_t;

    class search_scoreboard;
        logic [63:0]    key_mem [cis_pkg::DEPTH];  // biased so unsigned order is signed order
        search_result_t pending [$];
        int             errors;

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function int unsigned clog2(int unsigned x);
            int unsigned k;
            k = 0;
            while (k < 32 && (64'd1 << k) < x) k++;
            return k;
        endfunction

        // called for every accepted command word
        function void note(bit m, logic [63:0] key, logic [9:0] wi, logic [9:0] lo10,
                           logic signed [10:0] hi11);
            int             lo, hi, p;
            int unsigned    cap, used, probes;
            logic [63:0]    v, alo, ahi, ap;
            logic [127:0]   q;
            search_result_t r;
            if (!m) begin
                key_mem[wi] = key ^ 64'h8000_0000_0000_0000;
                return;
            end
            v = key ^ 64'h8000_0000_0000_0000;
            lo = lo10;
            hi = hi11;
            if (hi > cis_pkg::DEPTH - 1) hi = cis_pkg::DEPTH - 1;
            used = 0;
            probes = 0;
            r.hit = 0;
            r.pos = 0;
            if (lo <= hi) begin
                cap = clog2(hi - lo + 2) + 1;
                while (lo <= hi) begin
                    alo = key_mem[lo];
                    ahi = key_mem[hi];
                    if (alo > v || ahi < v) break;
                    if (alo == ahi) begin
                        probes++;
                        if (alo == v) begin
                            r.hit = 1;
                            r.pos = lo;
                        end
                        break;
                    end
                    if (used < cap) begin
                        q = v - alo;
                        q = q * 128'(hi - lo);
                        q = q / {64'd0, ahi - alo};
                        if (q > 128'(hi - lo)) q = 128'(hi - lo);
                        p = lo + int'(q);
                        used++;
                    end else begin
                        p = lo + (hi - lo) / 2;
                    end
                    probes++;
                    ap = key_mem[p];
                    if (ap == v) begin
                        r.hit = 1;
                        r.pos = p;
                        break;
                    end
                    if (ap < v) lo = p + 1;
                    else hi = p - 1;
                end
            end
            r.probes = probes > 31 ? 5'd31 : probes[4:0];
            pending = {pending, r};
        endfunction

        task check(bit f, bit [9:0] pos, bit [4:0] pc);
            search_result_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result found=%0d pos=%0d probes=%0d", f, pos, pc));
                return;
            end
            e = pending.pop_front();
            if (f !== e.hit) report($sformatf("found %0d, want %0d", f, e.hit));
            if (pos !== e.pos) report($sformatf("position %0d, want %0d", pos, e.pos));
            if (pc !== e.probes) report($sformatf("probe_count %0d, want %0d", pc, e.probes));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               mode;
    logic [63:0]        search_key;
    logic [9:0]         write_index;
    logic [9:0]         low_bound;
    logic signed [10:0] high_bound;
    logic               strobe;
    logic               found;
    logic [9:0]         position;
    logic [4:0]         probe_count;

    search_scoreboard sb;
    int               idle_pct;
    int               cycles;
    longint           keys [cis_pkg::DEPTH];

    capped_interpolation_search_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .search_key(search_key), .write_index(write_index), .low_bound(low_bound),
        .high_bound(high_bound), .strobe(strobe), .found(found), .position(position),
        .probe_count(probe_count)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result word is held for one full cycle; sample mid-cycle
    always @(negedge clk)
    begin
        if (rst_n && strobe) sb.check(found, position, probe_count);
    end

    // called at a rising edge; returns at the rising edge that took the word
    task send_word(bit m, logic [63:0] key, logic [9:0] wi, logic [9:0] lo,
                   logic signed [10:0] hi);
        bit taken;
        if ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct) @(posedge clk);
        end
        start <= 1;
        mode <= m;
        search_key <= key;
        write_index <= wi;
        low_bound <= lo;
        high_bound <= hi;
        taken = 0;
        while (!taken) begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        sb.note(m, key, wi, lo, hi);
    endtask

    // start drops at once so the last word is not taken again
    task drain();
        int n;
        n = 0;
        start <= 0;
        while (sb.pending.size() != 0 && n < 20000) begin
            @(posedge clk);
            n++;
        end
        repeat (400) @(posedge clk);
    endtask

    // writes n sorted keys into entries base .. base+n-1
    task load_array(int style, int base, int n);
        longint q [$];
        longint x;
        q = {};
        for (int i = 0; i < n; i++) begin
            case (style)
                0: x = {$urandom, $urandom};
                1: x = longint'($urandom_range(600)) - 300;   // narrow range of values, so duplicates can occur
                default: x = longint'({$urandom, $urandom}) >>> $urandom_range(63);
            endcase
            q = {q, x};
        end
        if (style == 0 && n > 1) begin
            q[0] = 64'sh8000_0000_0000_0000;
            q[1] = 64'sh7fff_ffff_ffff_ffff;
        end
        q.sort();
        for (int i = 0; i < n; i++) begin
            keys[base + i] = q[i];
            send_word(0, q[i], 10'(base + i), 0, 0);
        end
    endtask

    // half the searches stay in the low region that holds the short loads
    task random_search();
        int          lo, hi, i, top;
        logic [63:0] key;
        top = ($urandom_range(1) == 0) ? 63 : cis_pkg::DEPTH - 1;
        i = $urandom_range(top);
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: key = keys[i];
            6: key = keys[i] + 1;
            7: key = keys[i] - 1;
            default: key = {$urandom, $urandom};
        endcase
        lo = $urandom_range(top);
        if ($urandom_range(9) == 0) hi = int'($urandom_range(top + 1)) - 1;
        else hi = $urandom_range(top, lo);
        send_word(1, key, 0, 10'(lo), 11'(hi));
    endtask

    task random_mix(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(19) == 0)
                send_word(0, {$urandom, $urandom}, 10'($urandom_range(cis_pkg::DEPTH - 1)), 0, 0);
            else
                random_search();
        end
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        idle_pct = 0;
        start = 0;
        mode = 0;
        search_key = 0;
        write_index = 0;
        low_bound = 0;
        high_bound = 0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        idle_pct = 17;
        load_array(0, 0, cis_pkg::DEPTH);
        send_word(1, 64'h8000_0000_0000_0000, 0, 0, 1023);
        send_word(1, 64'h7fff_ffff_ffff_ffff, 0, 0, 1023);
        send_word(1, keys[500], 0, 0, 1023);
        send_word(1, keys[500] + 1, 0, 0, 1023);
        send_word(1, keys[0], 0, 3, 1023);            // key below low end
        send_word(1, keys[1023], 0, 0, 1000);         // key above high end
        send_word(1, keys[7], 0, 5, -1);              // empty bracket
        send_word(1, keys[7], 0, 9, 8);
        send_word(1, keys[1023], 0, 1023, 1023);      // single-entry bracket
        send_word(1, keys[1023], 0, 1023, 11'sd1023);
        send_word(1, keys[12], 0, 12, 12);
        send_word(1, keys[40], 0, 20, 40);
        send_word(1, keys[20], 0, 20, 40);
        send_word(1, 64'h0123_4567_89ab_cdef, 0, 0, 1023);
        random_mix(30);
        drain();

        idle_pct = 87;
        load_array(1, 0, 32);
        load_array(2, 32, 32);
        send_word(1, keys[20], 0, 0, 31);             // search over the narrow-range entries 0..31
        send_word(1, keys[20], 0, 20, 20);
        send_word(1, keys[20], 0, 0, 1023);
        send_word(0, 64'hffff_ffff_ffff_ffff, 700, 0, 0);  // breaks order
        send_word(1, -1, 0, 0, 1023);
        send_word(1, 0, 0, 0, 1023);
        random_mix(40);
        drain();

        idle_pct = 0;
        random_mix(60);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
